[rtl/core/linear_to_srgb_encode_assert.svh]
// Assertion macros for the sRGB encoder.
`ifndef LINEAR_TO_SRGB_ENCODE_ASSERT_SVH
`define LINEAR_TO_SRGB_ENCODE_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define LTSE_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Flag a condition that must never be seen outside reset.
`define LTSE_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

[rtl/core/ltse_pkg.sv]
package ltse_pkg;

   // Pipeline depth of one lane.
   localparam int NumStages = 8;
   // Segments in the log2 and exp2 interpolation tables.
   localparam int TableSegs = 64;

   typedef logic [NumStages-1:0] stage_en_type;
   typedef logic [30:0] seg_table_type [0:TableSegs];

   localparam longint unsigned Q30One = 64'd1 << 30;
   localparam longint unsigned FullScale = 64'd65535;
   // Largest code that takes the linear segment.
   localparam logic [15:0] LinThreshold = 16'((FullScale * 64'd31308) / 64'd10000000);

   // log2 of a Q30 mantissa in [1,2] with 28 fraction bits, by repeated squaring
   function automatic longint unsigned frac_log2(longint unsigned m_arg);
      longint unsigned m;
      longint unsigned r;
      m = m_arg;
      r = 0;
      if (m >= 2 * Q30One) begin
         r = 64'd1 << 28;
      end else begin
         if (m < Q30One) m = Q30One;
         for (int b = 0; b < 28; b++) begin
            m = (m * m) >> 30;
            r = r << 1;
            if (m >= 2 * Q30One) begin
               r = r | 64'd1;
               m = m >> 1;
            end
         end
      end
      return r;
   endfunction

   function automatic seg_table_type build_log();
      seg_table_type t;
      longint unsigned m;
      for (int i = 0; i <= TableSegs; i++) begin
         m = ((64'(TableSegs) + 64'(i)) << 30) / TableSegs;
         t[i] = 31'((frac_log2(m) + 64'd8) >> 4);
      end
      return t;
   endfunction

   function automatic seg_table_type build_exp();
      seg_table_type t;
      longint unsigned tgt;
      longint unsigned lo;
      longint unsigned hi;
      longint unsigned mid;
      for (int i = 0; i <= TableSegs; i++) begin
         tgt = (((64'(TableSegs) - 64'(i)) << 28) + 64'(TableSegs / 2)) / TableSegs;
         lo = Q30One >> 1;
         hi = Q30One;
         while (lo < hi) begin
            mid = (lo + hi) >> 1;
            if (frac_log2(mid << 1) >= tgt) hi = mid;
            else lo = mid + 64'd1;
         end
         t[i] = 31'(lo);
      end
      return t;
   endfunction

   localparam seg_table_type LogTable = build_log();
   localparam seg_table_type ExpTable = build_exp();

   // Q24 log2 of full scale, found the same way as in the lanes
   function automatic logic [28:0] log_full_scale();
      longint unsigned lo;
      longint unsigned hi;
      lo = 64'(LogTable[TableSegs-1]);
      hi = 64'(LogTable[TableSegs]);
      return 29'((64'd15 << 24) + lo + (((hi > lo ? hi - lo : 64'd0) * 64'd511) >> 9));
   endfunction

   localparam logic [28:0] LogFullScale = log_full_scale();
   // Reciprocals for the constant divides.
   localparam logic [19:0] RecipLin = 20'd671089;     // 2^26 / 100, rounded up
   localparam logic [31:0] RecipThree = 32'hAAAAAAAB; // 2^33 / 3, rounded up
   localparam logic [27:0] RecipOut = 28'd137438954;  // 2^34 / 125, rounded up

endpackage

[rtl/core/linear_to_srgb_encode.sv]
// Throughput: one pixel per cycle unless the output stalls with every
// stage full; three channel lanes run in parallel and each is an 8-stage
// pipeline that only stalls where a stage is occupied.
// A stalled output holds while empty stages upstream still take requests.
// Reset (synchronous, active high) clears all stage valid flags.
`include "linear_to_srgb_encode_assert.svh"
module linear_to_srgb_encode (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,  // red_linear, green_linear, blue_linear, zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata   // red_encoded, green_encoded, blue_encoded
);
   import ltse_pkg::*;

   logic [NumStages-1:0] valid_in, valid_ff;
   stage_en_type         stage_en;
   logic [15:0]          red_y, green_y, blue_y;

   // load a stage when it is empty or its contents move on
   always_comb begin
      stage_en[NumStages-1] = !valid_ff[NumStages-1] || rsp_tready;
      for (int s = NumStages - 2; s >= 0; s--) begin
         stage_en[s] = !valid_ff[s] || stage_en[s+1];
      end
      valid_in[0] = stage_en[0] ? req_tvalid : valid_ff[0];
      for (int s = 1; s < NumStages; s++) begin
         valid_in[s] = stage_en[s] ? valid_ff[s-1] : valid_ff[s];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   ltse_lane u_red (
      .clock           (clock),
      .stage_en        (stage_en),
      .channel_linear  (req_tdata[17:0]),
      .channel_encoded (red_y)
   );

   ltse_lane u_green (
      .clock           (clock),
      .stage_en        (stage_en),
      .channel_linear  (req_tdata[35:18]),
      .channel_encoded (green_y)
   );

   ltse_lane u_blue (
      .clock           (clock),
      .stage_en        (stage_en),
      .channel_linear  (req_tdata[53:36]),
      .channel_encoded (blue_y)
   );

   // merge the lane results into one response
   assign req_tready = stage_en[0];
   assign rsp_tvalid = valid_ff[NumStages-1];
   assign rsp_tdata  = {blue_y, green_y, red_y};

   `LTSE_NEVER(a_ready_with_room, !req_tready && !(&valid_ff), "stalled with an empty stage")
   `LTSE_ASSERT(a_mid_hold, valid_ff[3] && !stage_en[4] |=> valid_ff[3], "stage 4 lost a request")
   `LTSE_ASSERT(a_reset_empty, $past(reset) |-> !rsp_tvalid, "response right after reset")

endmodule

[rtl/core/ltse_lane.sv]
module ltse_lane (
   input  logic                  clock,
   input  ltse_pkg::stage_en_type stage_en,
   input  logic signed [17:0]    channel_linear,
   output logic [15:0]           channel_encoded
);
   import ltse_pkg::*;

   // stage 1: clamp, linear numerator, leading one
   logic [15:0] x_in, x_ff;
   logic [18:0] linv_in, linv_ff;
   logic [3:0]  e_in, e_ff;
   logic        lin_in;
   logic        lin_ff [0:NumStages-2];

   always_comb begin
      if (channel_linear[17]) x_in = 16'd0;
      else if (channel_linear[16]) x_in = 16'hFFFF;
      else x_in = channel_linear[15:0];
      lin_in  = (x_in <= LinThreshold);
      linv_in = 19'(x_in[7:0]) * 19'd1292 + 19'd50;
      e_in    = 4'd0;
      for (int b = 0; b < 16; b++) begin
         if (x_in[b]) e_in = 4'(b);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         x_ff      <= x_in;
         linv_ff   <= linv_in;
         e_ff      <= e_in;
      end
   end

   // stage 2: normalize, log table lookup and slope product, linear divide
   logic [15:0] norm;
   logic [14:0] frac;
   logic [24:0] llo, lhi, ldiff;
   logic [33:0] lprod;
   logic [38:0] linq;
   logic [24:0] llo_in, llo_ff, lslope_in, lslope_ff;
   logic [3:0]  e2_ff;
   logic [15:0] ylin_in;
   logic [15:0] ylin_ff [1:NumStages-2];

   always_comb begin
      norm      = x_ff << (4'd15 - e_ff);
      frac      = norm[14:0];
      llo       = LogTable[{1'b0, frac[14:9]}][24:0];
      lhi       = LogTable[{1'b0, frac[14:9]} + 7'd1][24:0];
      ldiff     = (lhi > llo) ? lhi - llo : 25'd0;
      lprod     = 34'(ldiff) * 34'(frac[8:0]);
      llo_in    = llo;
      lslope_in = 25'(lprod >> 9);
      linq      = 39'(linv_ff) * 39'(RecipLin);
      ylin_in   = 16'(linq >> 26);
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         llo_ff     <= llo_in;
         lslope_ff  <= lslope_in;
         e2_ff      <= e_ff;
      end
   end

   // stage 3: finish log2, distance from full scale, times 5/12 numerator
   logic [28:0] lval, u_in, u_ff;
   logic [27:0] adist;
   logic [30:0] tnum;

   always_comb begin
      lval  = {e2_ff, 25'd0} >> 1;
      lval  = lval + 29'(llo_ff) + 29'(lslope_ff);
      adist = (LogFullScale > lval) ? 28'(LogFullScale - lval) : 28'd0;
      tnum  = {1'b0, adist, 2'b00} + 31'(adist) + 31'd6;
      u_in  = 29'(tnum >> 2);
   end

   always_ff @(posedge clock) begin
      if (stage_en[2]) u_ff <= u_in;
   end

   // stage 4: divide by three
   logic [60:0] qprod;
   logic [26:0] q_in, q_ff;

   always_comb begin
      qprod = 61'(u_ff) * 61'(RecipThree);
      q_in  = 27'(qprod >> 33);
   end

   always_ff @(posedge clock) begin
      if (stage_en[3]) q_ff <= q_in;
   end

   // stage 5: exp table lookup and slope product
   logic [30:0] ehi, elo, ediff;
   logic [48:0] eprod;
   logic [30:0] ehi_in, ehi_ff, eslope_in, eslope_ff;
   logic [2:0]  k_ff;

   always_comb begin
      ehi       = ExpTable[{1'b0, q_ff[23:18]}];
      elo       = ExpTable[{1'b0, q_ff[23:18]} + 7'd1];
      ediff     = (ehi > elo) ? ehi - elo : 31'd0;
      eprod     = 49'(ediff) * 49'(q_ff[17:0]);
      ehi_in    = ehi;
      eslope_in = 31'(eprod >> 18);
   end

   always_ff @(posedge clock) begin
      if (stage_en[4]) begin
         ehi_ff    <= ehi_in;
         eslope_ff <= eslope_in;
         k_ff      <= q_ff[26:24];
      end
   end

   // stage 6: interpolate, scale by integer power, times 1055
   logic [30:0] pval;
   logic [40:0] w_in, w_ff;

   always_comb begin
      pval = (ehi_ff - eslope_ff) >> k_ff;
      w_in = 41'(pval) * 41'd1055;
   end

   always_ff @(posedge clock) begin
      if (stage_en[5]) w_ff <= w_in;
   end

   // stage 7: subtract offset, round, scale to full scale
   localparam logic [40:0] Offset = 41'd55 << 30;
   logic [40:0] wsub;
   logic [33:0] w2;
   logic [49:0] num;
   logic [23:0] u2_in, u2_ff;

   always_comb begin
      wsub  = (w_ff > Offset) ? w_ff - Offset : 41'd0;
      w2    = 34'((wsub + 41'd128) >> 8);
      num   = (50'(w2) << 16) - 50'(w2) + (50'd500 << 22);
      u2_in = 24'(num >> 25);
   end

   always_ff @(posedge clock) begin
      if (stage_en[6]) u2_ff <= u2_in;
   end

   // stage 8: divide by 125, saturate, pick segment
   logic [51:0] yprod;
   logic [17:0] ypow;
   logic [15:0] y_in, y_ff;

   always_comb begin
      yprod = 52'(u2_ff) * 52'(RecipOut);
      ypow  = 18'(yprod >> 34);
      y_in  = (ypow > 18'hFFFF) ? 16'hFFFF : ypow[15:0];
      if (lin_ff[NumStages-2]) y_in = ylin_ff[NumStages-2];
   end

   always_ff @(posedge clock) begin
      if (stage_en[7]) y_ff <= y_in;
   end

   // advance the segment flag and linear result alongside
   always_ff @(posedge clock) begin
      if (stage_en[0]) lin_ff[0] <= lin_in;
      if (stage_en[1]) ylin_ff[1] <= ylin_in;
      for (int s = 1; s < NumStages - 1; s++) begin
         if (stage_en[s]) lin_ff[s] <= lin_ff[s-1];
      end
      for (int s = 2; s < NumStages - 1; s++) begin
         if (stage_en[s]) ylin_ff[s] <= ylin_ff[s-1];
      end
   end

   assign channel_encoded = y_ff;

endmodule

[verif/linear_to_srgb_encode_tb.sv]
`timescale 1ns / 100ps

// Expected-pixel store: holds predicted encoded pixels in acceptance order.
class srgb_pixel_scoreboard;
   logic [47:0] pending_pixels[$];
   int unsigned mismatch_count;
   int unsigned checked_count;

   function void note_request(logic [47:0] predicted);
      pending_pixels.push_back(predicted);
   endfunction

   function void check_response(logic [47:0] actual);
      logic [47:0] predicted;
      string chan_name[3];
      chan_name[0] = "red_encoded";
      chan_name[1] = "green_encoded";
      chan_name[2] = "blue_encoded";
      if (pending_pixels.size() == 0) begin
         $error("response with no pixel pending: %h", actual);
         mismatch_count++;
         return;
      end
      predicted = pending_pixels.pop_front();
      checked_count++;
      for (int c = 0; c < 3; c++) begin
         if (predicted[c*16 +: 16] !== actual[c*16 +: 16]) begin
            $error("%s expected %0d actual %0d", chan_name[c],
                   predicted[c*16 +: 16], actual[c*16 +: 16]);
            mismatch_count++;
         end
      end
   endfunction
endclass

module linear_to_srgb_encode_tb;
   import ltse_pkg::*;

   localparam int Segs = 64;
   localparam longint unsigned FullCode = 64'd65535;
   localparam longint unsigned OneQ30 = 64'd1 << 30;
   localparam int WatchdogLimit = 20000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [55:0] req_tdata;   // red_linear, green_linear, blue_linear, zero pad
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;   // red_encoded, green_encoded, blue_encoded

   longint unsigned log_points[0:Segs];
   longint unsigned exp_points[0:Segs];
   srgb_pixel_scoreboard pixel_board;
   int  send_idle_pct;
   int  recv_stall_pct;
   bit  hold_off_recv;
   int  idle_cycles;
   int  sent_count;
   int  clamp_count;
   int  linear_count;

   linear_to_srgb_encode u_top (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // log2 of Q30 mantissa in [1,2], 28 fraction bits, by squaring
   function automatic longint unsigned mantissa_log2(longint unsigned m_in);
      longint unsigned m;
      longint unsigned r;
      m = m_in;
      r = 0;
      if (m >= 2 * OneQ30) return 64'd1 << 28;
      if (m < OneQ30) m = OneQ30;
      for (int b = 0; b < 28; b++) begin
         m = (m * m) >> 30;
         r = r << 1;
         if (m >= 2 * OneQ30) begin
            r = r | 1;
            m = m >> 1;
         end
      end
      return r;
   endfunction

   task automatic fill_segment_tables();
      longint unsigned tgt;
      longint unsigned lo;
      longint unsigned hi;
      longint unsigned mid;
      for (int i = 0; i <= Segs; i++) begin
         log_points[i] = (mantissa_log2(((64'(Segs) + i) << 30) / Segs) + 8) >> 4;
         tgt = (((64'(Segs) - i) << 28) + Segs / 2) / Segs;
         lo = OneQ30 >> 1;
         hi = OneQ30;
         while (lo < hi) begin
            mid = (lo + hi) >> 1;
            if (mantissa_log2(mid << 1) >= tgt) hi = mid;
            else lo = mid + 1;
         end
         exp_points[i] = lo;
      end
   endtask

   function automatic longint unsigned log2_fixed(longint unsigned x);
      int e;
      longint unsigned m;
      longint unsigned p;
      longint unsigned idx;
      longint unsigned d;
      e = 0;
      while (e < 62 && (x >> (e + 1)) != 0) e++;
      m = (e <= 30) ? (x << (30 - e)) : (x >> (e - 30));
      p = (m - OneQ30) * Segs;
      idx = p >> 30;
      if (idx >= Segs) idx = Segs - 1;
      d = (log_points[idx+1] > log_points[idx]) ? log_points[idx+1] - log_points[idx] : 0;
      return (64'(e) << 24) + log_points[idx] + ((d * (p & (OneQ30 - 1))) >> 30);
   endfunction

   // gamma-encode one 18-bit signed linear channel
   function automatic logic [15:0] encode_linear(logic signed [17:0] raw);
      longint unsigned x;
      longint unsigned a;
      longint unsigned q;
      longint unsigned k;
      longint unsigned gp;
      longint unsigned j;
      longint unsigned s;
      longint unsigned hi;
      longint unsigned lo;
      longint unsigned p;
      longint unsigned w;
      longint unsigned y;
      longint unsigned lx;
      longint unsigned lfs;
      if (raw < 0) return 16'd0;
      x = (raw > 18'sd65535) ? FullCode : 64'(raw);
      if (x <= (FullCode * 31308) / 10000000) begin
         y = (x * 1292 + 50) / 100;
         return 16'((y > FullCode) ? FullCode : y);
      end
      lx = log2_fixed(x);
      lfs = log2_fixed(FullCode);
      a = (lfs > lx) ? lfs - lx : 0;
      q = (a * 5 + 6) / 12;
      k = q >> 24;
      gp = (q & 64'hFFFFFF) * Segs;
      j = gp >> 24;
      if (j >= Segs) j = Segs - 1;
      s = gp & 64'hFFFFFF;
      hi = exp_points[j];
      lo = exp_points[j+1];
      p = hi - ((((hi > lo) ? hi - lo : 0) * s) >> 24);
      p = (k < 31) ? (p >> k) : 0;
      w = p * 1055;
      w = (w > (64'd55 << 30)) ? w - (64'd55 << 30) : 0;
      w = (w + 128) >> 8;
      y = (w * FullCode + (64'd500 << 22)) / (64'd1000 << 22);
      if (y > FullCode) y = FullCode;
      return 16'(y);
   endfunction

   function automatic logic [17:0] pick_channel();
      int sel;
      sel = $urandom_range(0, 9);
      case (sel)
         0: return 18'($urandom_range(0, 260));
         1: return 18'($urandom_range(200, 215));
         2: return 18'($urandom_range(65530, 65535));
         3: return 18'($urandom_range(65536, 131071));
         4: return 18'($urandom);
         default: return 18'($urandom_range(0, 65535));
      endcase
   endfunction

   // offer one pixel and hold it until accepted
   task automatic send_pixel(logic [17:0] r, logic [17:0] g, logic [17:0] b);
      while (send_idle_pct > 0 && $urandom_range(1, 100) <= send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {2'b00, b, g, r};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pixel_board.note_request({encode_linear(b), encode_linear(g), encode_linear(r)});
      for (int c = 0; c < 3; c++) begin
         logic signed [17:0] v;
         v = (c == 0) ? r : (c == 1) ? g : b;
         if (v < 0 || v > 18'sd65535) clamp_count++;
         else if (v <= 205) linear_count++;
      end
      sent_count++;
   endtask

   task automatic drain_pending();
      req_tvalid <= 1'b0;
      while (pixel_board.pending_pixels.size() != 0) @(posedge clock);
   endtask

   // receiver stall, with an optional long hold-off
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else if (hold_off_recv) rsp_tready <= 1'b0;
      else rsp_tready <= !(recv_stall_pct > 0 && $urandom_range(1, 100) <= recv_stall_pct);
   end

   // compare accepted responses
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) pixel_board.check_response(rsp_tdata);
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
         $display("linear_to_srgb_encode_tb failed");
         $finish;
      end
   end

   initial begin
      logic [17:0] edge_vals[12];
      pixel_board = new();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_off_recv = 1'b0;
      sent_count = 0;
      clamp_count = 0;
      linear_count = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      fill_segment_tables();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: zero, threshold, knee, full scale, negatives, overrange
      edge_vals = '{18'd0, 18'd1, 18'd204, 18'd205, 18'd206, 18'd207, 18'd65534,
                    18'd65535, 18'd65536, 18'h1FFFF, 18'h20000, 18'h3FFFF};
      foreach (edge_vals[i]) send_pixel(edge_vals[i], edge_vals[11-i], edge_vals[(i+5)%12]);
      send_pixel(18'd32768, 18'd16384, 18'd1000);
      send_pixel(18'h2AAAA, 18'h15555, 18'd3000);

      // pause until every expected pixel has come
      drain_pending();

      // long receiver hold-off while requests keep coming
      fork
         begin
            hold_off_recv = 1'b1;
            repeat (60) @(posedge clock);
            hold_off_recv = 1'b0;
         end
         repeat (40) send_pixel(pick_channel(), pick_channel(), pick_channel());
      join

      // random phases
      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = (phase == 1 || phase == 3) ? 48 : 0;
         recv_stall_pct = (phase == 2) ? 48 : (phase == 3) ? 8 : 0;
         if (phase == 3) send_idle_pct = 8;
         repeat (450) send_pixel(pick_channel(), pick_channel(), pick_channel());
      end
      drain_pending();
      repeat (20) @(posedge clock);

      $display("covered %0d pixels: %0d clamped channels, %0d linear-segment channels",
               sent_count, clamp_count, linear_count);
      $display("checked %0d responses, %0d mismatches",
               pixel_board.checked_count, pixel_board.mismatch_count);
      if (pixel_board.mismatch_count == 0 && pixel_board.pending_pixels.size() == 0) begin
         $display("linear_to_srgb_encode_tb passed");
      end else begin
         $display("linear_to_srgb_encode_tb failed");
      end
      $finish;
   end
endmodule

[sim.f]
+incdir+rtl/core
rtl/core/ltse_pkg.sv
rtl/core/ltse_lane.sv
rtl/core/linear_to_srgb_encode.sv
verif/linear_to_srgb_encode_tb.sv
